// ----- src/vn2d_pkg.sv -----
// Shared constants for the 2D value noise pipeline and its checker.
package vn2d_pkg;

	// Coordinate format and internal weight precision
	localparam int unsigned FracBits   = 16;
	localparam int unsigned WeightBits = 24;

	// Pipeline depth from request to result register
	localparam int unsigned NumStages = 14;

	// Integer hash constants (all arithmetic mod 2^32)
	localparam logic [31:0] HashMulB = 32'd15731;
	localparam logic [31:0] HashAddB = 32'd789221;
	localparam logic [31:0] HashAddC = 32'd1376312589;

	// 1.0 in Q.30 and 3.0 in Q.24
	localparam logic signed [31:0] OneQ30   = 32'sh4000_0000;
	localparam logic [27:0]        ThreeQ24 = 28'h300_0000;

	// Output saturation limits, Q1.15
	localparam logic signed [25:0] NoiseMax = 26'sd32767;
	localparam logic signed [25:0] NoiseMin = -26'sd32768;

endpackage

// ----- src/value_noise_2d.sv -----
// Two-dimensional value noise: lattice hash, smoothstep weights, bilinear blend.
//
// Takes one point per request (coord_x, coord_y: signed fixed point with
// vn2d_pkg::FracBits fraction bits) and returns one Q1.15 noise sample.
// Integer parts truncate toward zero; the four lattice corners are hashed
// with the shift-xor / cubic integer hash in 32-bit wrapping arithmetic and
// mapped to values in (-1, 1]; the corners are blended first along x, then
// along y, with smoothstep weights of the fractional parts. Negative
// coordinates give a fractional part in (-1, 0], so the blend extrapolates
// there; the result saturates to [-32768, 32767]. Throughput is one request
// per clock cycle while results are taken, fully independent items. The
// hash chain has three dependent 32-bit multiplies (n*n, times 15731,
// times n); they are followed by two blend multiplies, each closed by its
// own register stage. Every stage carries a valid bit and holds on
// back-pressure; an empty stage anywhere lets the stages before it advance,
// so coord_ready stays high unless all 14 stages hold an item and the
// result is not being taken.
module value_noise_2d (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               coord_valid,
	output logic               coord_ready,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	output logic               noise_valid,
	input  logic               noise_ready,
	output logic signed [15:0] noise_value
);

	localparam int unsigned Ns = vn2d_pkg::NumStages;

	// Stage control: vld_q[k] marks stage k full, adv[k] lets it load
	logic [Ns:1] vld_q;
	logic [Ns:1] adv;

	// Integer part, truncated toward zero, wrapped to 32 bits
	function automatic logic [31:0] int_part(input logic [31:0] c);
		logic [31:0] mag;
		logic [31:0] ip;
		mag = c[31] ? (32'd0 - c) : c;
		ip  = mag >> vn2d_pkg::FracBits;
		return c[31] ? (32'd0 - ip) : ip;
	endfunction

	// Signed fractional part, scaled to Q.24
	function automatic logic signed [25:0] frac_part(input logic [31:0] c);
		logic [31:0] mag;
		logic [25:0] fr;
		mag = c[31] ? (32'd0 - c) : c;
		fr  = 26'(mag[vn2d_pkg::FracBits-1:0])
			<< (vn2d_pkg::WeightBits - vn2d_pkg::FracBits);
		return c[31] ? $signed(26'd0 - fr) : $signed(fr);
	endfunction

	// Pipeline data registers
	logic [31:0]        xi_s1, yi_s1;
	logic signed [25:0] xf_s1, yf_s1;

	logic [31:0]        m00_s2;
	logic [47:0]        xtt_s2, ytt_s2;
	logic signed [25:0] xf_s2, yf_s2;

	logic [31:0] n_s3 [4];
	logic [24:0] xt2_s3, yt2_s3;
	logic [26:0] xfac_s3, yfac_s3;

	logic [31:0] n_s4 [4];
	logic [31:0] sq_s4 [4];
	logic [51:0] xsp_s4, ysp_s4;

	logic [31:0] n_s5 [4];
	logic [31:0] pp_s5 [4];
	logic [26:0] xs_s5, ys_s5;

	logic [31:0] q_s6 [4];
	logic [26:0] xs_s6, ys_s6;

	logic [30:0] h_s7 [4];
	logic [26:0] xs_s7, ys_s7;

	logic signed [31:0] a_s8 [2];
	logic signed [31:0] d_s8 [2];
	logic [26:0]        xs_s8, ys_s8;

	logic signed [31:0] a_s9 [2];
	logic signed [59:0] p_s9 [2];
	logic [26:0]        ys_s9;

	logic signed [35:0] l_s10 [2];
	logic [26:0]        ys_s10;

	logic signed [35:0] l0_s11;
	logic signed [36:0] dl_s11;
	logic [26:0]        ys_s11;

	logic signed [35:0] l0_s12;
	logic signed [64:0] pl_s12;

	logic signed [40:0] r30_s13;

	logic signed [15:0] noise_s14;

	// Combinational helpers
	logic signed [51:0] xsq, ysq;
	logic [48:0]        xt2_sum, yt2_sum;
	logic [27:0]        xfac_w, yfac_w;
	logic [31:0]        m_w [4];
	logic [52:0]        xs_sum, ys_sum;
	logic [31:0]        hq_w [4];
	logic signed [59:0] pr_w [2];
	logic signed [64:0] plr_w;
	logic signed [40:0] rr_w;
	logic signed [25:0] r15_w;

	// Ready chain: a stage loads when it is empty or the next one loads
	assign adv[Ns] = ~vld_q[Ns] | noise_ready;
	for (genvar k = 1; k < Ns; k++) begin : g_adv
		assign adv[k] = ~vld_q[k] | adv[k+1];
	end

	assign coord_ready = adv[1];
	assign noise_valid = vld_q[Ns];
	assign noise_value = noise_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= coord_valid;
			end
			for (int k = 2; k <= Ns; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_comb begin
		xsq     = xf_s1 * xf_s1;
		ysq     = yf_s1 * yf_s1;
		// round t*t to Q.24
		xt2_sum = 49'(xtt_s2) + 49'(1 << (vn2d_pkg::WeightBits - 1));
		yt2_sum = 49'(ytt_s2) + 49'(1 << (vn2d_pkg::WeightBits - 1));
		// 3 - 2t, always positive
		xfac_w  = vn2d_pkg::ThreeQ24 - {xf_s2[25], xf_s2, 1'b0};
		yfac_w  = vn2d_pkg::ThreeQ24 - {yf_s2[25], yf_s2, 1'b0};
		// corner order: (x,y), (x+1,y), (x,y+1), (x+1,y+1)
		m_w[0]  = m00_s2;
		m_w[1]  = m00_s2 + 32'd1;
		m_w[2]  = m00_s2 + 32'd257;
		m_w[3]  = m00_s2 + 32'd258;
		xs_sum  = 53'(xsp_s4) + 53'(1 << (vn2d_pkg::WeightBits - 1));
		ys_sum  = 53'(ysp_s4) + 53'(1 << (vn2d_pkg::WeightBits - 1));
		for (int c = 0; c < 4; c++) begin
			hq_w[c] = q_s6[c] + vn2d_pkg::HashAddC;
		end
		for (int j = 0; j < 2; j++) begin
			pr_w[j] = p_s9[j] + 60'sd8388608;
		end
		plr_w = pl_s12 + 65'sd8388608;
		rr_w  = r30_s13 + 41'sd16384;
		r15_w = rr_w[40:15];
	end

	// Stage 1: split coordinates
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			xi_s1 <= int_part(coord_x);
			yi_s1 <= int_part(coord_y);
			xf_s1 <= frac_part(coord_x);
			yf_s1 <= frac_part(coord_y);
		end
	end

	// Stage 2: lattice index xi + 257*yi, square the fractions
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			m00_s2 <= xi_s1 + {yi_s1[23:0], 8'd0} + yi_s1;
			xtt_s2 <= xsq[47:0];
			ytt_s2 <= ysq[47:0];
			xf_s2  <= xf_s1;
			yf_s2  <= yf_s1;
		end
	end

	// Stage 3: shift-xor per corner, weight factors
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int c = 0; c < 4; c++) begin
				n_s3[c] <= (m_w[c] << 13) ^ m_w[c];
			end
			xt2_s3  <= xt2_sum[48:24];
			yt2_s3  <= yt2_sum[48:24];
			xfac_s3 <= xfac_w[26:0];
			yfac_s3 <= yfac_w[26:0];
		end
	end

	// Stage 4: n*n, t2*(3-2t)
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int c = 0; c < 4; c++) begin
				sq_s4[c] <= n_s3[c] * n_s3[c];
				n_s4[c]  <= n_s3[c];
			end
			xsp_s4 <= 52'(xt2_s3) * 52'(xfac_s3);
			ysp_s4 <= 52'(yt2_s3) * 52'(yfac_s3);
		end
	end

	// Stage 5: n*n*15731 + 789221, round weights
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int c = 0; c < 4; c++) begin
				pp_s5[c] <= sq_s4[c] * vn2d_pkg::HashMulB + vn2d_pkg::HashAddB;
				n_s5[c]  <= n_s4[c];
			end
			xs_s5 <= xs_sum[50:24];
			ys_s5 <= ys_sum[50:24];
		end
	end

	// Stage 6: n * polynomial
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int c = 0; c < 4; c++) begin
				q_s6[c] <= n_s5[c] * pp_s5[c];
			end
			xs_s6 <= xs_s5;
			ys_s6 <= ys_s5;
		end
	end

	// Stage 7: final add, drop the sign bit
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			for (int c = 0; c < 4; c++) begin
				h_s7[c] <= hq_w[c][30:0];
			end
			xs_s7 <= xs_s6;
			ys_s7 <= ys_s6;
		end
	end

	// Stage 8: corner values a = 1 - h and x-differences b - a = h_a - h_b
	always_ff @(posedge clk) begin
		if (adv[8]) begin
			for (int j = 0; j < 2; j++) begin
				a_s8[j] <= vn2d_pkg::OneQ30 - $signed({1'b0, h_s7[2*j]});
				d_s8[j] <= $signed({1'b0, h_s7[2*j]}) - $signed({1'b0, h_s7[2*j+1]});
			end
			xs_s8 <= xs_s7;
			ys_s8 <= ys_s7;
		end
	end

	// Stage 9: scale x-differences by the x weight
	always_ff @(posedge clk) begin
		if (adv[9]) begin
			for (int j = 0; j < 2; j++) begin
				p_s9[j] <= $signed({1'b0, xs_s8}) * d_s8[j];
				a_s9[j] <= a_s8[j];
			end
			ys_s9 <= ys_s8;
		end
	end

	// Stage 10: finish the x blends
	always_ff @(posedge clk) begin
		if (adv[10]) begin
			for (int j = 0; j < 2; j++) begin
				l_s10[j] <= 36'(a_s9[j]) + $signed(pr_w[j][59:24]);
			end
			ys_s10 <= ys_s9;
		end
	end

	// Stage 11: y-difference
	always_ff @(posedge clk) begin
		if (adv[11]) begin
			dl_s11 <= 37'(l_s10[1]) - 37'(l_s10[0]);
			l0_s11 <= l_s10[0];
			ys_s11 <= ys_s10;
		end
	end

	// Stage 12: scale by the y weight
	always_ff @(posedge clk) begin
		if (adv[12]) begin
			pl_s12 <= $signed({1'b0, ys_s11}) * dl_s11;
			l0_s12 <= l0_s11;
		end
	end

	// Stage 13: finish the y blend in Q.30
	always_ff @(posedge clk) begin
		if (adv[13]) begin
			r30_s13 <= 41'(l0_s12) + $signed(plr_w[64:24]);
		end
	end

	// Stage 14: round to Q1.15 and saturate; this is the result register
	always_ff @(posedge clk) begin
		if (adv[14]) begin
			if (r15_w > vn2d_pkg::NoiseMax) begin
				noise_s14 <= 16'sh7fff;
			end else if (r15_w < vn2d_pkg::NoiseMin) begin
				noise_s14 <= -16'sh8000;
			end else begin
				noise_s14 <= r15_w[15:0];
			end
		end
	end

endmodule

// ----- src/vn2d_chk.sv -----
// Port-level checker for value_noise_2d, bound into every value_noise_2d instance.
module vn2d_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               coord_valid,
	input logic               coord_ready,
	input logic               noise_valid,
	input logic               noise_ready,
	input logic signed [15:0] noise_value
);

	localparam int unsigned CntW = $clog2(vn2d_pkg::NumStages + 1);

	logic [CntW-1:0] cnt_q;
	logic            in_acc;
	logic            out_acc;

	assign in_acc  = coord_valid & coord_ready;
	assign out_acc = noise_valid & noise_ready;

	// Track requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CntW'(in_acc) - CntW'(out_acc);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid && !noise_ready |=> noise_valid && $stable(noise_value))
		else $error("result changed or dropped while stalled");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(vn2d_pkg::NumStages))
		else $error("more requests in flight than stages");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid |-> cnt_q != '0)
		else $error("result without a request in flight");

	a_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q < CntW'(vn2d_pkg::NumStages) || noise_ready) |-> coord_ready)
		else $error("request refused while pipeline has room");

endmodule

bind value_noise_2d vn2d_chk u_vn2d_chk (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for value_noise_2d: request driver, result monitor, noise predictor.
module tb;

	// Predictor formats: coordinate fraction bits, weight bits, Q1.15 limits
	localparam int unsigned CoordFrac = 16;
	localparam int unsigned WeightQ   = 24;
	localparam longint      OneQ24    = 64'sd1 <<< WeightQ;
	localparam longint      UnitQ30   = 64'sd1 <<< 30;
	localparam longint      SampleHi  = 64'sd32767;
	localparam longint      SampleLo  = -64'sd32768;

	// Lattice hash constants, all products mod 2^32
	localparam logic [31:0] RowStride = 32'd257;
	localparam logic [31:0] CubicMul  = 32'd15731;
	localparam logic [31:0] CubicAdd  = 32'd789221;
	localparam logic [31:0] HashBias  = 32'd1376312589;
	localparam logic [31:0] HashMask  = 32'h7fff_ffff;

	// Run control
	localparam int unsigned PhaseItems = 375;
	localparam int unsigned HoldCycles = 80;
	localparam int unsigned QuietLimit = 4000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} coord_pair_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               coord_valid = 1'b0;
	logic               coord_ready;
	logic signed [31:0] coord_x = '0;
	logic signed [31:0] coord_y = '0;
	logic               noise_valid;
	logic               noise_ready = 1'b0;
	logic signed [15:0] noise_value;

	coord_pair_t        pending_points[$];
	logic signed [15:0] expected_noise[$];

	int unsigned issued       = 0;
	int unsigned req_count    = 0;
	int unsigned err_count    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned stall_pct       = 0;
	int unsigned hold_left       = 0;
	logic        req_fire  = 1'b0;
	logic        hold_armed = 1'b0;
	logic        hold_done  = 1'b0;

	value_noise_2d uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.coord_valid(coord_valid),
		.coord_ready(coord_ready),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.noise_valid(noise_valid),
		.noise_ready(noise_ready),
		.noise_value(noise_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Noise predictor
	// ------------------------------------------------------------------

	// Round half up, then drop k bits: floor((p + 2^(k-1)) / 2^k)
	function automatic longint round_shift(longint p, int unsigned k);
		return (p + (64'sd1 <<< (k - 1))) >>> k;
	endfunction

	// Split a coordinate into a truncated lattice index and a signed Q.24 fraction.
	// Negative coordinates give a fraction in (-1, 0].
	function automatic void split_coord(input logic signed [31:0] c,
			output logic [31:0] ipart, output longint frac);
		logic [32:0] mag;
		mag   = c[31] ? (33'd0 - {c[31], c}) : {1'b0, c};
		ipart = mag[31:0] >> CoordFrac;
		frac  = longint'({48'd0, mag[CoordFrac-1:0]}) <<< (WeightQ - CoordFrac);
		if (c[31]) begin
			ipart = 32'd0 - ipart;
			frac  = -frac;
		end
	endfunction

	// Hash one lattice corner and map it to 1 - h/2^30 in Q.30
	function automatic longint lattice_value(logic [31:0] xi, logic [31:0] yi);
		logic [31:0] n;
		n = xi + yi * RowStride;
		n = (n << 13) ^ n;
		n = (n * (n * n * CubicMul + CubicAdd) + HashBias) & HashMask;
		return UnitQ30 - longint'({32'd0, n});
	endfunction

	// Smoothstep weight t*t*(3 - 2t) in Q.24, each product rounded
	function automatic longint smooth_weight(longint t);
		longint t2;
		t2 = round_shift(t * t, WeightQ);
		return round_shift(t2 * (3 * OneQ24 - 2 * t), WeightQ);
	endfunction

	function automatic longint lerp_q30(longint s, longint a, longint b);
		return a + round_shift(s * (b - a), WeightQ);
	endfunction

	function automatic logic signed [15:0] noise_sample(logic signed [31:0] x,
			logic signed [31:0] y);
		logic [31:0] xi, yi;
		longint      xf, yf, xs, ys, row0, row1, r;
		split_coord(x, xi, xf);
		split_coord(y, yi, yf);
		xs   = smooth_weight(xf);
		ys   = smooth_weight(yf);
		row0 = lerp_q30(xs, lattice_value(xi, yi), lattice_value(xi + 32'd1, yi));
		row1 = lerp_q30(xs, lattice_value(xi, yi + 32'd1),
			lattice_value(xi + 32'd1, yi + 32'd1));
		r    = round_shift(lerp_q30(ys, row0, row1), 15);
		// Saturate: an exact +1.0 and any extrapolated overshoot clamp here
		if (r > SampleHi) r = SampleHi;
		if (r < SampleLo) r = SampleLo;
		return r[15:0];
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Fractions at the boundaries: zero, one ulp, just under and at one half, just under one
	function automatic logic [15:0] pick_frac();
		case ($urandom_range(4))
			0:       return 16'h0000;
			1:       return 16'h0001;
			2:       return 16'h7fff;
			3:       return 16'h8000;
			default: return 16'hffff;
		endcase
	endfunction

	function automatic logic signed [31:0] random_coord();
		logic [31:0] raw;
		raw = $urandom();
		case ($urandom_range(3))
			// full 32-bit range, covers every bit
			0: ;
			// lattice neighborhood around the origin, both signs
			1: raw = {{14{raw[31]}}, raw[17:0]};
			// any cell, boundary fraction
			2: raw[15:0] = pick_frac();
			// near the origin with a boundary fraction
			default: raw = {{14{raw[31]}}, raw[17:16], pick_frac()};
		endcase
		return raw;
	endfunction

	task automatic queue_point(logic signed [31:0] x, logic signed [31:0] y);
		coord_pair_t p;
		p.x = x;
		p.y = y;
		pending_points.push_back(p);
		issued++;
	endtask

	task automatic queue_random(int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			queue_point(random_coord(), random_coord());
		end
	endtask

	// Hold the sender until every request is taken and every sample is back.
	// Poll on the falling edge, where the monitor's counters are stable, and
	// return on a rising edge so new settings never race the driver.
	task automatic wait_drained();
		do @(negedge clk);
		while (req_count != issued || expected_noise.size() != 0);
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Request driver: change inputs on the falling edge only
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_requests
		coord_pair_t nxt;
		// Advance only when the slot is empty or the last request was taken
		if (arst_n && (!coord_valid || req_fire)) begin
			if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				nxt = pending_points.pop_front();
				coord_valid <= 1'b1;
				coord_x     <= nxt.x;
				coord_y     <= nxt.y;
			end else begin
				coord_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random stalls plus one long hold-off on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_ready
		if (hold_left != 0) begin
			hold_left   <= hold_left - 1;
			noise_ready <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			// Drop ready long enough for all pipeline stages to fill and stall the input
			hold_left   <= HoldCycles - 1;
			hold_done   <= 1'b1;
			noise_ready <= 1'b0;
		end else begin
			noise_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample both channels on the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_samples
		logic signed [15:0] want;
		req_fire <= coord_valid && coord_ready;
		if (arst_n) begin
			// Predict at acceptance, before checking, so ordering is kept
			if (coord_valid && coord_ready) begin
				expected_noise.push_back(noise_sample(coord_x, coord_y));
				req_count <= req_count + 1;
			end
			if (noise_valid && noise_ready) begin
				if (expected_noise.size() == 0) begin
					$error("noise_value: sample with no request outstanding, got %0d",
						noise_value);
					err_count++;
				end else begin
					want = expected_noise.pop_front();
					if (noise_value !== want) begin
						$error("noise_value: expected %0d, got %0d", want, noise_value);
						err_count++;
					end
				end
			end
		end
	end

	// Watchdog: end the run once nothing has moved on either channel for too long
	always @(posedge clk) begin : watchdog
		if ((coord_valid && coord_ready) || (noise_valid && noise_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < QuietLimit) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : run_test
		int unsigned idle_plan [5];
		int unsigned stall_plan[5];
		idle_plan  = '{0, 58, 0, 27, 0};
		stall_plan = '{0, 0, 58, 27, 0};

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: origin, unit steps, field extremes, boundary fractions
		queue_point(32'sh0000_0000, 32'sh0000_0000);
		queue_point(32'sh0001_0000, 32'sh0000_0000);
		queue_point(32'sh0000_0000, 32'sh0001_0000);
		queue_point(32'sh0000_8000, 32'sh0000_8000);
		queue_point(32'sh0000_ffff, 32'sh0000_ffff);
		queue_point(32'sh0000_0001, 32'sh0000_0001);
		queue_point(32'sh7fff_ffff, 32'sh7fff_ffff);
		queue_point(32'sh8000_0000, 32'sh8000_0000);
		queue_point(32'sh7fff_ffff, 32'sh8000_0000);
		queue_point(32'sh8000_0000, 32'sh7fff_ffff);
		queue_point(32'sh8000_0001, 32'sh0000_0000);
		queue_point(32'sh7fff_0000, 32'sh8001_0000);
		// Negative side: truncation toward zero, fraction in (-1, 0]
		queue_point(32'shffff_ffff, 32'shffff_ffff);
		queue_point(32'shffff_8000, 32'shffff_8000);
		queue_point(32'shffff_0000, 32'shffff_0000);
		// Fraction just above -1: weight near 5, strong extrapolation and saturation
		queue_point(32'shffff_0001, 32'shffff_0001);
		queue_point(32'shfffe_0001, 32'sh0000_0005);
		queue_point(32'sh0003_0001, 32'shfffd_0001);
		queue_point(32'shffff_0001, 32'sh0000_ffff);
		queue_point(32'sh0001_0000, 32'shffff_0000);
		queue_point(32'sh1234_5678, 32'shedcb_a987);
		queue_point(32'sh5555_5555, 32'shaaaa_aaaa);
		wait_drained();

		// Random phases; each ends with the sender paused until all samples are back
		for (int p = 0; p < 5; p++) begin
			sender_idle_pct = idle_plan[p];
			stall_pct       = stall_plan[p];
			// First phase: long receiver hold-off while requests keep coming
			if (p == 0) hold_armed = 1'b1;
			queue_random(PhaseItems);
			wait_drained();
		end

		// Let any stray sample surface before the verdict
		repeat (2 * vn2d_pkg::NumStages) @(posedge clk);
		@(negedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
